/* rtl/idsd_pkg.sv */
// Package: opcodes, register indexes, microcode word and microcode ROM for the impedance block.
`timescale 1ns / 1ps
`default_nettype none
package idsd_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned GAIN_W = 31;
  localparam int unsigned OPA_W  = 34;
  localparam int unsigned OPB_W  = 32;
  localparam int unsigned PROD_W = OPA_W + OPB_W;
  localparam int unsigned RND_W  = PROD_W - 32;
  localparam int unsigned UPC_W  = 4;

  // dt = 0.005 and dt*dt/2 as unsigned Q0.32
  localparam logic signed [OPB_W-1:0] DT_Q32    = 32'sd21474836;
  localparam logic signed [OPB_W-1:0] DTSQH_Q32 = 32'sd53687;

  localparam logic signed [PROD_W-1:0] SAT_MAX = 66'sh7FFF_FFFF;
  localparam logic signed [PROD_W-1:0] SAT_MIN = -66'sh8000_0000;
  localparam logic signed [PROD_W-1:0] HALF_Q32 = 66'sh8000_0000;

  typedef enum logic [1:0] {
    OP_FORCE = 2'd0,
    OP_TICK  = 2'd1,
    OP_LOAD  = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    REG_DAMPING   = 3'd0,
    REG_STIFFNESS = 3'd1,
    REG_KICK_GAIN = 3'd2,
    REG_POS_LIMIT = 3'd3,
    REG_DEADZONE  = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {A_ACCEL, A_VEL, A_POS, A_OPND} a_sel_t;
  typedef enum logic [2:0] {B_DT, B_DTSQH, B_DAMP, B_STIFF, B_KICK} b_sel_t;
  typedef enum logic [2:0] {
    ACC_HOLD, ACC_POS_RND, ACC_ADD_RND, ACC_NEG_PROD, ACC_SUB_PROD
  } acc_op_t;
  typedef enum logic [2:0] {
    WR_NONE, WR_EXCESS, WR_KICK, WR_VEL, WR_POS, WR_ACCEL, WR_LOAD, WR_EMIT
  } wr_t;
  typedef enum logic [1:0] {J_NEXT, J_ALWAYS, J_NOKICK} jmp_t;

  typedef struct packed {
    a_sel_t            a_sel;
    b_sel_t            b_sel;
    logic              mul_en;
    acc_op_t           acc_op;
    wr_t               wr;
    jmp_t              jmp;
    logic [UPC_W-1:0]  target;
  } ucode_t;

  // microcode addresses
  localparam logic [UPC_W-1:0] UA_CHECK     = 4'd0;
  localparam logic [UPC_W-1:0] UA_KICK_MUL  = 4'd1;
  localparam logic [UPC_W-1:0] UA_KICK_LOAD = 4'd2;
  localparam logic [UPC_W-1:0] UA_INT0      = 4'd3;
  localparam logic [UPC_W-1:0] UA_INT1      = 4'd4;
  localparam logic [UPC_W-1:0] UA_INT2      = 4'd5;
  localparam logic [UPC_W-1:0] UA_INT3      = 4'd6;
  localparam logic [UPC_W-1:0] UA_INT4      = 4'd7;
  localparam logic [UPC_W-1:0] UA_INT5      = 4'd8;
  localparam logic [UPC_W-1:0] UA_INT6      = 4'd9;
  localparam logic [UPC_W-1:0] UA_INT7      = 4'd10;
  localparam logic [UPC_W-1:0] UA_EMIT      = 4'd11;
  localparam logic [UPC_W-1:0] UA_LOAD      = 4'd12;

  function automatic ucode_t uc(input a_sel_t a, input b_sel_t b, input logic m,
                                input acc_op_t ac, input wr_t w, input jmp_t j,
                                input logic [UPC_W-1:0] t);
    ucode_t r;
    r.a_sel  = a;
    r.b_sel  = b;
    r.mul_en = m;
    r.acc_op = ac;
    r.wr     = w;
    r.jmp    = j;
    r.target = t;
    return r;
  endfunction

  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] addr);
    ucode_t r;
    case (addr)
      UA_CHECK:     r = uc(A_OPND,  B_DT,    1'b0, ACC_HOLD,     WR_EXCESS, J_NOKICK, UA_INT0);
      UA_KICK_MUL:  r = uc(A_OPND,  B_KICK,  1'b1, ACC_HOLD,     WR_NONE,   J_NEXT,   UA_EMIT);
      UA_KICK_LOAD: r = uc(A_OPND,  B_DT,    1'b0, ACC_HOLD,     WR_KICK,   J_NEXT,   UA_EMIT);
      UA_INT0:      r = uc(A_ACCEL, B_DT,    1'b1, ACC_HOLD,     WR_NONE,   J_NEXT,   UA_EMIT);
      UA_INT1:      r = uc(A_ACCEL, B_DTSQH, 1'b1, ACC_HOLD,     WR_VEL,    J_NEXT,   UA_EMIT);
      UA_INT2:      r = uc(A_VEL,   B_DT,    1'b1, ACC_POS_RND,  WR_NONE,   J_NEXT,   UA_EMIT);
      UA_INT3:      r = uc(A_VEL,   B_DT,    1'b0, ACC_ADD_RND,  WR_NONE,   J_NEXT,   UA_EMIT);
      UA_INT4:      r = uc(A_VEL,   B_DAMP,  1'b1, ACC_HOLD,     WR_POS,    J_NEXT,   UA_EMIT);
      UA_INT5:      r = uc(A_POS,   B_STIFF, 1'b1, ACC_NEG_PROD, WR_NONE,   J_NEXT,   UA_EMIT);
      UA_INT6:      r = uc(A_POS,   B_DT,    1'b0, ACC_SUB_PROD, WR_NONE,   J_NEXT,   UA_EMIT);
      UA_INT7:      r = uc(A_POS,   B_DT,    1'b0, ACC_HOLD,     WR_ACCEL,  J_NEXT,   UA_EMIT);
      UA_EMIT:      r = uc(A_POS,   B_DT,    1'b0, ACC_HOLD,     WR_EMIT,   J_ALWAYS, UA_EMIT);
      UA_LOAD:      r = uc(A_POS,   B_DT,    1'b0, ACC_HOLD,     WR_LOAD,   J_ALWAYS, UA_EMIT);
      default:      r = uc(A_POS,   B_DT,    1'b0, ACC_HOLD,     WR_EMIT,   J_ALWAYS, UA_EMIT);
    endcase
    return r;
  endfunction

  function automatic logic [UPC_W-1:0] entry_addr(input logic [1:0] op);
    logic [UPC_W-1:0] a;
    case (op)
      OP_FORCE: a = UA_CHECK;
      OP_TICK:  a = UA_INT0;
      OP_LOAD:  a = UA_LOAD;
      default:  a = UA_EMIT;
    endcase
    return a;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SAT_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/impedance_deadzone_spring_damper.sv */
// Top level: microcoded unit-mass spring-damper impedance model with force-error kick.
//
// Usage:
//  - Input channel (in_valid / in_stall) carries one request: opcode, target_force,
//    measured_force, accel_value. Opcode 0 is a force step, 1 a free integration
//    tick, 2 loads the acceleration, 3 does nothing. Every request gives one result.
//  - Output channel (out_valid / out_stall) returns position, Q16.16, after the step.
//  - Config port: cfg_write, cfg_index, cfg_data writes damping, stiffness, kick gain,
//    position limit and deadzone; write only while no request is in flight.
//  - After accept, force step: deadzone check, kick multiply and load if a kick fires,
//    then integrate and emit; tick: integrate, emit; load and opcode 3 end in emit.
//    One request is worked on at a time; the single shared 34x32 multiplier and the
//    dependent multiply chain (a*dt, a*dt^2/2, v*dt, c*v, k*x) set the step count.
//  - in_stall is high while a request runs. The finished position sits in an output
//    register, so the next request is taken while it waits; if the receiver still
//    stalls when the next one finishes, the sequencer parks on its emit step.
//  - Reset (rst, synchronous): pos/vel/accel zero, kick armed, registers to defaults.
`timescale 1ns / 1ps
`default_nettype none
module impedance_deadzone_spring_damper #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  opcode,
  input  wire logic [31:0] target_force,
  input  wire logic [31:0] measured_force,
  input  wire logic [31:0] accel_value,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      position,
  // configuration
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [30:0] cfg_data
);
  import idsd_pkg::*;

  // Kick limit is 180 in Q format, held to the 32-bit range.
  localparam logic [63:0] KICK_RAW = 64'd180 << FRAC_BITS;
  localparam logic [31:0] KICK_LIM = (KICK_RAW > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF
                                                                : KICK_RAW[31:0];
  localparam logic [63:0] DZ_RAW   = 64'd30 << FRAC_BITS;
  localparam logic [GAIN_W-1:0] DZ_RESET = DZ_RAW[GAIN_W-1:0];
  localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(64'd1 << (FRAC_BITS - 1));

  // configuration registers
  logic [GAIN_W-1:0] damping_gain, stiffness_gain, kick_gain, position_limit, force_deadzone;

  // model state
  logic signed [DATA_W-1:0] pos, vel, accel;
  logic                     kick_armed;
  logic [1:0]               steps_since_kick;

  // sequencer
  logic             busy;
  logic [UPC_W-1:0] upc, upc_next;
  ucode_t           cw;

  // request latch and datapath
  logic [1:0]               op_q;
  logic                     neg;
  logic [32:0]              opnd;       // |err|, then excess over deadzone; or load value
  logic signed [PROD_W-1:0] prod, acc;
  logic signed [OPA_W-1:0]  mul_a;
  logic signed [OPB_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] mul_p;

  logic                     in_acc, emit_go, kick_ok;
  logic signed [32:0]       err;
  logic [32:0]              err_mag;
  logic signed [PROD_W-1:0] prod_half;
  logic signed [RND_W-1:0]  prod_rnd;
  logic signed [DATA_W-1:0] vel_new, pos_sat, pos_new, bound, accel_new;
  logic signed [PROD_W-1:0] acc_half, kick_q;
  logic [DATA_W-1:0]        kick_mag;
  logic [1:0]               steps_inc;

  assign cw       = ucode_rom(upc);
  assign in_stall = busy;
  assign in_acc   = in_valid && !in_stall;
  // emit step completes only once the output register is free
  assign emit_go  = busy && (cw.wr == WR_EMIT) && !(out_valid && out_stall);

  // force error, exact at 33 bits
  assign err     = {target_force[31], target_force} - {measured_force[31], measured_force};
  assign err_mag = err[32] ? 33'(-err) : 33'(err);

  assign kick_ok = (opnd > {2'b00, force_deadzone}) && kick_armed;

  // shared multiplier operands
  always_comb begin
    case (cw.a_sel)
      A_ACCEL: mul_a = OPA_W'(accel);
      A_VEL:   mul_a = OPA_W'(vel);
      A_POS:   mul_a = OPA_W'(pos);
      A_OPND:  mul_a = signed'({1'b0, opnd});
      default: mul_a = '0;
    endcase
    case (cw.b_sel)
      B_DT:    mul_b = DT_Q32;
      B_DTSQH: mul_b = DTSQH_Q32;
      B_DAMP:  mul_b = signed'({1'b0, damping_gain});
      B_STIFF: mul_b = signed'({1'b0, stiffness_gain});
      B_KICK:  mul_b = signed'({1'b0, kick_gain});
      default: mul_b = '0;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Q0.32 product rounded to nearest, ties up
  assign prod_half = prod + HALF_Q32;
  assign prod_rnd  = prod_half[PROD_W-1:32];

  assign vel_new = sat32(PROD_W'(vel) + PROD_W'(prod_rnd));

  // position saturate, then clamp on force steps
  assign bound   = signed'({1'b0, position_limit});
  assign pos_sat = sat32(acc);
  always_comb begin
    pos_new = pos_sat;
    if (op_q == OP_FORCE) begin
      if (pos_sat > bound) begin
        pos_new = bound;
      end else if (pos_sat < -bound) begin
        pos_new = -bound;
      end
    end
  end

  assign acc_half  = acc + HALF_LSB;
  assign accel_new = sat32(acc_half >>> FRAC_BITS);

  // kick: kp * excess, truncated, limited in magnitude
  assign kick_q   = prod >>> FRAC_BITS;
  assign kick_mag = ($unsigned(kick_q) > {{(PROD_W-DATA_W){1'b0}}, KICK_LIM}) ? KICK_LIM
                                                                              : kick_q[31:0];

  assign steps_inc = (steps_since_kick == 2'd2) ? 2'd2 : steps_since_kick + 2'd1;

  // step counter with conditional jump
  always_comb begin
    case (cw.jmp)
      J_NEXT:   upc_next = upc + UPC_W'(1);
      J_ALWAYS: upc_next = cw.target;
      J_NOKICK: upc_next = kick_ok ? upc + UPC_W'(1) : cw.target;
      default:  upc_next = cw.target;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      upc       <= UA_EMIT;
      out_valid <= 1'b0;
    end else begin
      if (in_acc) begin
        busy <= 1'b1;
        upc  <= entry_addr(opcode);
      end else if (emit_go) begin
        busy <= 1'b0;
      end else if (busy && cw.wr != WR_EMIT) begin
        upc <= upc_next;
      end
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      position <= pos;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      damping_gain   <= '0;
      stiffness_gain <= '0;
      kick_gain      <= '0;
      position_limit <= '1;
      force_deadzone <= DZ_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DAMPING:   damping_gain   <= cfg_data;
        REG_STIFFNESS: stiffness_gain <= cfg_data;
        REG_KICK_GAIN: kick_gain      <= cfg_data;
        REG_POS_LIMIT: position_limit <= cfg_data;
        REG_DEADZONE:  force_deadzone <= cfg_data;
        default: ;
      endcase
    end
  end

  // request latch, product and accumulator (payload, no reset)
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_q <= opcode;
      neg  <= err[32];
      opnd <= (opcode == OP_LOAD) ? {1'b0, accel_value} : err_mag;
    end else if (busy && cw.wr == WR_EXCESS) begin
      opnd <= opnd - {2'b00, force_deadzone};
    end
    if (busy && cw.mul_en) begin
      prod <= mul_p;
    end
    if (busy) begin
      case (cw.acc_op)
        ACC_POS_RND:  acc <= PROD_W'(pos) + PROD_W'(prod_rnd);
        ACC_ADD_RND:  acc <= acc + PROD_W'(prod_rnd);
        ACC_NEG_PROD: acc <= -prod;
        ACC_SUB_PROD: acc <= acc - prod;
        default: ;
      endcase
    end
  end

  // model state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos              <= '0;
      vel              <= '0;
      accel            <= '0;
      kick_armed       <= 1'b1;
      steps_since_kick <= 2'd0;
    end else if (busy) begin
      case (cw.wr)
        WR_KICK: begin
          accel            <= neg ? -signed'(kick_mag) : signed'(kick_mag);
          kick_armed       <= 1'b0;
          steps_since_kick <= 2'd0;
        end
        WR_VEL: vel <= vel_new;
        WR_POS: pos <= pos_new;
        WR_ACCEL: begin
          accel <= accel_new;
          if (op_q == OP_FORCE) begin
            steps_since_kick <= steps_inc;
            if (steps_inc == 2'd2) begin
              kick_armed <= 1'b1;
            end
          end
        end
        WR_LOAD: accel <= signed'(opnd[31:0]);
        default: ;
      endcase
    end
  end

  // a result only appears at the end of a running request
  a_emit_ends_run: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(busy) && !busy)
    else $error("result emitted outside a running request");

  // once two force steps have passed since a kick, kicks are armed
  a_rearm: assert property (@(posedge clk) disable iff (rst)
    (steps_since_kick == 2'd2) |-> kick_armed)
    else $error("kick not re-armed after two force steps");

  a_steps_range: assert property (@(posedge clk) disable iff (rst)
    steps_since_kick != 2'd3)
    else $error("steps since kick passed saturation");

endmodule
`default_nettype wire
